// ----- design/assert_macros.svh -----
// Assertion macros shared by the prefix code checker RTL.
// Clocked on aclk and disabled while aresetn is low; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PCCC_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("pccc assertion failed");
`define PCCC_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("pccc forbidden condition seen");
`else
`define PCCC_ASSERT(label, prop)
`define PCCC_ASSERT_NEVER(label, cond)
`endif
`endif

// ----- design/pccc_pkg.sv -----
// Package for the prefix code conflict checker: sizes, trie node type, sequencer states.
// No dependencies.
package pccc_pkg;

    localparam int NODES    = 256;
    localparam int IDX_W    = $clog2(NODES);
    localparam int CNT_W    = IDX_W + 1;
    localparam int CODE_W   = 16;
    localparam int BIT_W    = $clog2(CODE_W);
    localparam int LEN_W    = 5;
    localparam int MAX_LEN  = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 8;

    localparam logic REQ_CLEAR = 1'b1;

    typedef struct packed {
        logic             end_flag;
        logic [IDX_W-1:0] child1;
        logic [IDX_W-1:0] child0;
    } pccc_node_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOOK,
        ST_FINISH
    } pccc_state_t;

endpackage

// ----- design/prefix_code_conflict_checker_unit.sv -----
// Prefix code conflict checker: a trie of codewords in a node memory, walked by a sequencer.
// Depends on pccc_pkg and assert_macros.svh.
//
// One request is taken at a time; s_tready is high only while the unit is idle. A clear or an
// empty code goes straight to the finish state, which raises m_tvalid once the output is free.
// An insert walks the code one bit per trie level. Each node on the path, the root included,
// takes a registered read of the single-port node memory, then lookup and write-back, if it
// already existed; a node allocated during this insert skips the read. The last node's
// lookup is the end-node check. The walk stops early on a conflict or an exhausted pool, and
// s_tready returns in the cycle m_tvalid rises if the output is free. Clear is immediate:
// per-node valid bits are all dropped at once, so there is no clearing pass after reset.
`default_nettype none

module prefix_code_conflict_checker_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [15:0] code_bits, [20:16] code_len, [23:21] zero
    input  wire logic [pccc_pkg::S_DATA_W-1:0] s_tdata,
    // [0] req_type
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [0] code_conflict, [1] set_decodable, [2] pool_overflow, [7:3] zero
    output logic [pccc_pkg::M_DATA_W-1:0]      m_tdata
);

    pccc_pkg::pccc_state_t state_reg, state_next;

    logic [pccc_pkg::IDX_W-1:0]  node_reg, node_next;
    logic [pccc_pkg::LEN_W-1:0]  rem_reg, rem_next;
    logic [pccc_pkg::CODE_W-1:0] bits_reg, bits_next;
    logic                        fresh_reg, fresh_next;
    logic [pccc_pkg::CNT_W-1:0]  next_free_reg, next_free_next;
    logic                        set_ok_reg, set_ok_next;
    logic                        conflict_reg, conflict_next;
    logic                        overflow_reg, overflow_next;
    logic                        m_valid_reg, m_valid_next;
    logic [2:0]                  m_data_reg, m_data_next;

    pccc_pkg::pccc_node_t mem [pccc_pkg::NODES];
    pccc_pkg::pccc_node_t rd_data_reg;
    logic                 rd_valid_reg;
    logic [pccc_pkg::NODES-1:0] valid_reg;

    logic                        in_xfer;
    logic                        clear_req;
    logic [pccc_pkg::CODE_W-1:0] in_bits;
    logic [pccc_pkg::LEN_W-1:0]  in_len;
    logic [pccc_pkg::LEN_W-1:0]  sat_len;
    logic                        out_free;

    pccc_pkg::pccc_node_t        cur;
    pccc_pkg::pccc_node_t        wr_data;
    logic                        mem_we;
    logic [pccc_pkg::BIT_W-1:0]  bit_idx;
    logic                        walk_bit;
    logic [pccc_pkg::IDX_W-1:0]  slot;
    logic                        look_end;
    logic                        look_last;
    logic                        look_alloc;
    logic                        look_ovf;
    logic                        has_child;

    assign in_bits   = s_tdata[pccc_pkg::CODE_W-1:0];
    assign in_len    = s_tdata[pccc_pkg::CODE_W +: pccc_pkg::LEN_W];
    assign sat_len   = (in_len > pccc_pkg::LEN_W'(pccc_pkg::MAX_LEN))
                       ? pccc_pkg::LEN_W'(pccc_pkg::MAX_LEN) : in_len;
    assign s_tready  = (state_reg == pccc_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign clear_req = in_xfer && (s_tuser == pccc_pkg::REQ_CLEAR);
    assign out_free  = !m_valid_reg || m_tready;

    // lookup of the current node
    assign cur        = fresh_reg ? '0 : (rd_valid_reg ? rd_data_reg : '0);
    assign bit_idx    = pccc_pkg::BIT_W'(rem_reg - pccc_pkg::LEN_W'(1));
    assign walk_bit   = bits_reg[bit_idx];
    assign slot       = walk_bit ? cur.child1 : cur.child0;
    assign has_child  = (cur.child0 != '0) || (cur.child1 != '0);
    assign look_end   = cur.end_flag;
    assign look_last  = (rem_reg == '0);
    assign look_alloc = (slot == '0);
    assign look_ovf   = next_free_reg[pccc_pkg::CNT_W-1];

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pccc_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_tuser == pccc_pkg::REQ_CLEAR || in_len == '0) begin
                        state_next = pccc_pkg::ST_FINISH;
                    end else begin
                        state_next = pccc_pkg::ST_READ;
                    end
                end
            end
            pccc_pkg::ST_READ: begin
                state_next = pccc_pkg::ST_LOOK;
            end
            pccc_pkg::ST_LOOK: begin
                if (look_end || look_last) begin
                    state_next = pccc_pkg::ST_FINISH;
                end else if (look_alloc) begin
                    state_next = look_ovf ? pccc_pkg::ST_FINISH : pccc_pkg::ST_LOOK;
                end else begin
                    state_next = pccc_pkg::ST_READ;
                end
            end
            pccc_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pccc_pkg::ST_IDLE;
                end
            end
            default: state_next = pccc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        node_next      = node_reg;
        rem_next       = rem_reg;
        bits_next      = bits_reg;
        fresh_next     = fresh_reg;
        next_free_next = next_free_reg;
        set_ok_next    = set_ok_reg;
        conflict_next  = conflict_reg;
        overflow_next  = overflow_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        mem_we         = 1'b0;
        wr_data        = cur;
        unique case (state_reg)
            pccc_pkg::ST_IDLE: begin
                conflict_next = 1'b0;
                overflow_next = 1'b0;
                if (clear_req) begin
                    next_free_next = pccc_pkg::CNT_W'(1);
                    set_ok_next    = 1'b1;
                end else if (in_xfer) begin
                    node_next  = '0;
                    rem_next   = sat_len;
                    bits_next  = in_bits;
                    fresh_next = 1'b0;
                end
            end
            pccc_pkg::ST_READ: begin
            end
            pccc_pkg::ST_LOOK: begin
                if (look_end) begin
                    conflict_next = 1'b1;
                    set_ok_next   = 1'b0;
                end else if (look_last) begin
                    mem_we           = 1'b1;
                    wr_data.end_flag = 1'b1;
                    if (has_child) begin
                        conflict_next = 1'b1;
                        set_ok_next   = 1'b0;
                    end
                end else if (look_alloc) begin
                    if (look_ovf) begin
                        overflow_next = 1'b1;
                    end else begin
                        mem_we = 1'b1;
                        if (walk_bit) begin
                            wr_data.child1 = next_free_reg[pccc_pkg::IDX_W-1:0];
                        end else begin
                            wr_data.child0 = next_free_reg[pccc_pkg::IDX_W-1:0];
                        end
                        node_next      = next_free_reg[pccc_pkg::IDX_W-1:0];
                        next_free_next = next_free_reg + pccc_pkg::CNT_W'(1);
                        fresh_next     = 1'b1;
                        rem_next       = rem_reg - pccc_pkg::LEN_W'(1);
                    end
                end else begin
                    node_next  = slot;
                    fresh_next = 1'b0;
                    rem_next   = rem_reg - pccc_pkg::LEN_W'(1);
                end
            end
            pccc_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {overflow_reg, set_ok_reg, conflict_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pccc_pkg::ST_IDLE;
            next_free_reg <= pccc_pkg::CNT_W'(1);
            set_ok_reg    <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            set_ok_reg    <= set_ok_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        node_reg     <= node_next;
        rem_reg      <= rem_next;
        bits_reg     <= bits_next;
        fresh_reg    <= fresh_next;
        conflict_reg <= conflict_next;
        overflow_reg <= overflow_next;
        m_data_reg   <= m_data_next;
    end

    // node memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[node_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg  <= mem[node_reg];
        rd_valid_reg <= valid_reg[node_reg];
    end

    // an entry without its valid bit reads as an empty node
    always_ff @(posedge aclk) begin
        if (!aresetn || clear_req) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[node_reg] <= 1'b1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(pccc_pkg::M_DATA_W - 3)'(0), m_data_reg};

`include "assert_macros.svh"

    `PCCC_ASSERT(a_pool_bound, next_free_reg <= pccc_pkg::CNT_W'(pccc_pkg::NODES))
    `PCCC_ASSERT_NEVER(a_conflict_and_ovf, m_tvalid && m_tdata[0] && m_tdata[2])
    `PCCC_ASSERT(a_conflict_clears_ok, (m_tvalid && m_tdata[0]) |-> !m_tdata[1])
    `PCCC_ASSERT(a_clear_resets, clear_req |=> (next_free_reg == pccc_pkg::CNT_W'(1)) && set_ok_reg)

endmodule

`default_nettype wire
